// File: design/i2c_master_byte_sequencer_core_macros.svh
// Assertion macros shared by the I2C byte sequencer RTL.
`ifndef I2C_MASTER_BYTE_SEQUENCER_CORE_MACROS_SVH
`define I2C_MASTER_BYTE_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication checked on every clock edge outside reset.
`define I2CMBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define I2CMBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/i2cmbs_pkg.sv
// Types, codes and helpers for the I2C master byte sequencer.
package i2cmbs_pkg;

    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_START    = 3'd1;
    localparam logic [2:0] CMD_STOP     = 3'd2;
    localparam logic [2:0] CMD_WRITE    = 3'd3;
    localparam logic [2:0] CMD_RD_ACK   = 3'd4;
    localparam logic [2:0] CMD_RD_NACK  = 3'd5;

    localparam int unsigned BITS_PER_BYTE = 8;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_ST_A     = 4'd1,
        PH_ST_B     = 4'd2,
        PH_SP_A     = 4'd3,
        PH_SP_B     = 4'd4,
        PH_SP_C     = 4'd5,
        PH_WR_SETUP = 4'd6,
        PH_WR_HIGH  = 4'd7,
        PH_WR_LOW   = 4'd8,
        PH_AK_REL   = 4'd9,
        PH_AK_HIGH  = 4'd10,
        PH_AK_POLL  = 4'd11,
        PH_RD_LOW   = 4'd12,
        PH_RD_HIGH  = 4'd13,
        PH_AO_LOW   = 4'd14,
        PH_AO_HIGH  = 4'd15
    } phase_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       sda_sample;
    } item_t;

    typedef struct packed {
        phase_t     phase;
        logic [9:0] wait_count;
        logic [3:0] bit_count;
        logic [7:0] shift;
        logic [7:0] poll_count;
        logic       send_ack;
        logic       scl;
        logic       sda;
        logic       sda_en;
        logic       ack_fail;
        logic [7:0] rx_hold;
    } seq_state_t;

    // Declared from the highest bit down so that scl_level lands in bit 0.
    typedef struct packed {
        logic       ack_failed;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_enable;
        logic       sda_level;
        logic       scl_level;
    } result_t;

    // Tick count for a delay of us microseconds; a zero rate counts as one.
    function automatic logic [9:0] delay_ticks(input logic [2:0] us,
                                               input logic [7:0] tpu);
        logic [7:0]  t;
        logic [10:0] prod;
        t    = (tpu == 8'd0) ? 8'd1 : tpu;
        prod = 11'(us) * 11'(t);
        return prod[9:0];
    endfunction

endpackage

// File: design/i2cmbs_step.sv
// Next-state and result logic for one tick of the I2C byte sequencer.
module i2cmbs_step
    import i2cmbs_pkg::*;
(
    input  seq_state_t cur,
    input  item_t      item,
    input  logic [7:0] ticks_per_us,
    input  logic [7:0] ack_timeout,
    output seq_state_t nxt,
    output result_t    res
);

    logic done;

    always_comb begin
        nxt  = cur;
        done = 1'b0;
        priority if (cur.phase == PH_IDLE) begin
            unique case (item.cmd)
                CMD_START: begin
                    nxt.sda_en     = 1'b1;
                    nxt.sda        = 1'b1;
                    nxt.scl        = 1'b1;
                    nxt.phase      = PH_ST_A;
                    nxt.wait_count = delay_ticks(3'd4, ticks_per_us);
                end
                CMD_STOP: begin
                    nxt.sda_en     = 1'b1;
                    nxt.scl        = 1'b0;
                    nxt.sda        = 1'b0;
                    nxt.phase      = PH_SP_A;
                    nxt.wait_count = delay_ticks(3'd4, ticks_per_us);
                end
                CMD_WRITE: begin
                    nxt.shift      = item.tx_byte;
                    nxt.bit_count  = 4'd0;
                    nxt.poll_count = 8'd0;
                    nxt.sda_en     = 1'b1;
                    nxt.scl        = 1'b0;
                    nxt.sda        = item.tx_byte[7];
                    nxt.phase      = PH_WR_SETUP;
                    nxt.wait_count = delay_ticks(3'd2, ticks_per_us);
                end
                CMD_RD_ACK, CMD_RD_NACK: begin
                    nxt.send_ack   = (item.cmd == CMD_RD_ACK);
                    nxt.bit_count  = 4'd0;
                    nxt.shift      = 8'd0;
                    nxt.sda_en     = 1'b0;
                    nxt.scl        = 1'b0;
                    nxt.phase      = PH_RD_LOW;
                    nxt.wait_count = delay_ticks(3'd2, ticks_per_us);
                end
                default: begin
                    // No command, or a code with no meaning: stay idle.
                end
            endcase
        end else if (cur.phase == PH_AK_POLL) begin
            priority if (!item.sda_sample) begin
                nxt.scl      = 1'b0;
                nxt.ack_fail = 1'b0;
                nxt.phase    = PH_IDLE;
                done         = 1'b1;
            end else if (cur.poll_count >= ack_timeout) begin
                // Timeout leaves SCL high and SDA released.
                nxt.ack_fail = 1'b1;
                nxt.phase    = PH_IDLE;
                done         = 1'b1;
            end else begin
                nxt.poll_count = cur.poll_count + 8'd1;
            end
        end else if (cur.wait_count > 10'd1) begin
            nxt.wait_count = cur.wait_count - 10'd1;
        end else begin
            unique case (cur.phase)
                PH_ST_A: begin
                    nxt.sda        = 1'b0;
                    nxt.phase      = PH_ST_B;
                    nxt.wait_count = delay_ticks(3'd4, ticks_per_us);
                end
                PH_ST_B: begin
                    nxt.scl   = 1'b0;
                    nxt.phase = PH_IDLE;
                    done      = 1'b1;
                end
                PH_SP_A: begin
                    nxt.scl        = 1'b1;
                    nxt.phase      = PH_SP_B;
                    nxt.wait_count = delay_ticks(3'd1, ticks_per_us);
                end
                PH_SP_B: begin
                    nxt.sda        = 1'b1;
                    nxt.phase      = PH_SP_C;
                    nxt.wait_count = delay_ticks(3'd4, ticks_per_us);
                end
                PH_SP_C: begin
                    nxt.phase = PH_IDLE;
                    done      = 1'b1;
                end
                PH_WR_SETUP: begin
                    nxt.scl        = 1'b1;
                    nxt.phase      = PH_WR_HIGH;
                    nxt.wait_count = delay_ticks(3'd2, ticks_per_us);
                end
                PH_WR_HIGH: begin
                    nxt.scl        = 1'b0;
                    nxt.phase      = PH_WR_LOW;
                    nxt.wait_count = delay_ticks(3'd2, ticks_per_us);
                end
                PH_WR_LOW: begin
                    nxt.shift     = {cur.shift[6:0], 1'b0};
                    nxt.bit_count = cur.bit_count + 4'd1;
                    if (cur.bit_count + 4'd1 < 4'(BITS_PER_BYTE)) begin
                        nxt.sda        = cur.shift[6];
                        nxt.phase      = PH_WR_SETUP;
                        nxt.wait_count = delay_ticks(3'd2, ticks_per_us);
                    end else begin
                        nxt.sda_en     = 1'b0;
                        nxt.sda        = 1'b1;
                        nxt.phase      = PH_AK_REL;
                        nxt.wait_count = delay_ticks(3'd1, ticks_per_us);
                    end
                end
                PH_AK_REL: begin
                    nxt.scl        = 1'b1;
                    nxt.phase      = PH_AK_HIGH;
                    nxt.wait_count = delay_ticks(3'd1, ticks_per_us);
                end
                PH_AK_HIGH: begin
                    nxt.phase      = PH_AK_POLL;
                    nxt.poll_count = 8'd0;
                end
                PH_RD_LOW: begin
                    nxt.scl        = 1'b1;
                    nxt.phase      = PH_RD_HIGH;
                    nxt.wait_count = delay_ticks(3'd1, ticks_per_us);
                end
                PH_RD_HIGH: begin
                    nxt.shift     = {cur.shift[6:0], item.sda_sample};
                    nxt.bit_count = cur.bit_count + 4'd1;
                    nxt.scl       = 1'b0;
                    if (cur.bit_count + 4'd1 < 4'(BITS_PER_BYTE)) begin
                        nxt.phase      = PH_RD_LOW;
                        nxt.wait_count = delay_ticks(3'd2, ticks_per_us);
                    end else begin
                        nxt.sda_en     = 1'b1;
                        nxt.sda        = !cur.send_ack;
                        nxt.phase      = PH_AO_LOW;
                        nxt.wait_count = delay_ticks(3'd2, ticks_per_us);
                    end
                end
                PH_AO_LOW: begin
                    nxt.scl        = 1'b1;
                    nxt.phase      = PH_AO_HIGH;
                    nxt.wait_count = delay_ticks(3'd2, ticks_per_us);
                end
                PH_AO_HIGH: begin
                    nxt.scl     = 1'b0;
                    nxt.rx_hold = cur.shift;
                    nxt.phase   = PH_IDLE;
                    done        = 1'b1;
                end
                default: begin
                    nxt.phase = PH_IDLE;
                end
            endcase
        end
    end

    assign res.scl_level  = nxt.scl;
    assign res.sda_level  = nxt.sda;
    assign res.sda_enable = nxt.sda_en;
    assign res.busy_res   = (nxt.phase != PH_IDLE);
    assign res.done_res   = done;
    assign res.rx_byte    = nxt.rx_hold;
    assign res.ack_failed = nxt.ack_fail;

endmodule

// File: design/i2c_master_byte_sequencer_core.sv
// Top level of the pin-level I2C master byte sequencer.
//
// Each input beat on the s_ channel is one timing tick: a command (taken
// only while idle), the byte to write and the sampled SDA level. Each tick
// yields exactly one result beat on the m_ channel with the SCL/SDA drive
// levels, busy and done flags, the last received byte and the ACK status.
// Bus delays last n * ticks_per_us ticks; cfg_addr 0 writes ticks_per_us,
// cfg_addr 1 writes ack_timeout. Write them only while the block is idle.
//
// An accepted input beat is held in the input register, then the sequencer
// step computes its result from it and loads the result register.
// Throughput is one beat per cycle while m_tready is high; the step of one
// tick is combinational and reads the state left by the previous tick.
//
// Synchronous reset puts SCL high and SDA driven high, idles the sequencer,
// clears the received byte and ACK status and empties both registers.
// When m_tready is low the result beat holds and the input register keeps
// one more tick; s_tready drops only once both are full.
module i2c_master_byte_sequencer_core
    import i2cmbs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] cmd, [10:3] tx_byte, [11] sda_sample, [15:12] zero
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] scl_level, [1] sda_level, [2] sda_enable, [3] busy_res,
    // [4] done_res, [12:5] rx_byte, [13] ack_failed, [15:14] zero
    output logic [15:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    `include "i2c_master_byte_sequencer_core_macros.svh"

    localparam logic CFG_TICKS_PER_US = 1'b0;
    localparam logic CFG_ACK_TIMEOUT  = 1'b1;

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    result_t    out_data_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    res_next;
    logic [7:0] ticks_per_us_reg;
    logic [7:0] ack_timeout_reg;
    logic       fire;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

    i2cmbs_step u_step (
        .cur          (state_reg),
        .item         (in_item_reg),
        .ticks_per_us (ticks_per_us_reg),
        .ack_timeout  (ack_timeout_reg),
        .nxt          (state_next),
        .res          (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_per_us_reg <= 8'd1;
            ack_timeout_reg  <= 8'd250;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_TICKS_PER_US: ticks_per_us_reg <= cfg_wdata;
                CFG_ACK_TIMEOUT:  ack_timeout_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_IDLE, wait_count: 10'd0, bit_count: 4'd0,
                               shift: 8'd0, poll_count: 8'd0, send_ack: 1'b0,
                               scl: 1'b1, sda: 1'b1, sda_en: 1'b1,
                               ack_fail: 1'b0, rx_hold: 8'd0};
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= '{cmd: s_tdata[2:0], tx_byte: s_tdata[10:3],
                             sda_sample: s_tdata[11]};
        end
        if (fire) begin
            out_data_reg <= res_next;
        end
    end

    `I2CMBS_ASSERT_NOW(a_done_not_busy, out_valid_reg,
        !(out_data_reg.done_res && out_data_reg.busy_res),
        "result beat reports done while still busy")
    `I2CMBS_ASSERT_NOW(a_wait_nonzero,
        state_reg.phase != PH_IDLE && state_reg.phase != PH_AK_POLL,
        state_reg.wait_count != 10'd0,
        "timed phase entered with a zero delay count")
    `I2CMBS_ASSERT_NEXT(a_start_enters,
        fire && state_reg.phase == PH_IDLE && in_item_reg.cmd == CMD_START,
        state_reg.phase == PH_ST_A,
        "start command from idle did not enter the start phase")
    `I2CMBS_ASSERT_NEXT(a_item_kept, in_valid_reg && !fire, in_valid_reg,
        "held input beat dropped before it was stepped")

endmodule
